@@ hw/rtl/tfd_pkg.sv @@
// Shared types, codes and frame-layout tables for the telemetry frame deframer.
// Used by tfd_front, tfd_job_fifo, tfd_back and telemetry_frame_deframer.
package tfd_pkg;

   // Frame type codes.
   localparam logic [7:0] TYPE_STATUS  = 8'h01;
   localparam logic [7:0] TYPE_SENSORS = 8'h02;
   localparam logic [7:0] TYPE_RC      = 8'h03;
   localparam logic [7:0] TYPE_MOTORS  = 8'h06;
   localparam logic [7:0] TYPE_PID     = 8'h10;

   // Status byte value that means disarmed.
   localparam logic [7:0] DISARMED_CODE = 8'hA0;

   // Payload offset of the status frame's armed byte and its field slot.
   localparam logic [4:0] ARMED_OFFSET = 5'd6;
   localparam logic [3:0] ARMED_INDEX  = 4'd3;

   // Scale tags.
   localparam logic [1:0] SCALE_RAW        = 2'd0;
   localparam logic [1:0] SCALE_HUNDREDTHS = 2'd1;
   localparam logic [1:0] SCALE_THOUSANDTHS = 2'd2;

   // One validated frame, handed from the parser to the field emitter.
   typedef struct packed {
      logic [7:0] frame_type;
      logic       bank;
   } job_type;

   // Return of a payload bank once all its fields have gone out.
   typedef struct packed {
      logic en;
      logic bank;
   } release_type;

   // Number of result words a frame type produces (0 for unknown types).
   function automatic logic [3:0] field_total(input logic [7:0] frame_type);
      logic [3:0] total;
      case (frame_type)
         TYPE_STATUS:  total = 4'd4;
         TYPE_SENSORS: total = 4'd9;
         TYPE_RC:      total = 4'd10;
         TYPE_MOTORS:  total = 4'd4;
         TYPE_PID:     total = 4'd9;
         default:      total = 4'd0;
      endcase
      return total;
   endfunction

   // Minimum payload length the layout of a frame type needs.
   function automatic logic [7:0] min_length(input logic [7:0] frame_type);
      logic [7:0] need;
      case (frame_type)
         TYPE_STATUS:  need = 8'd7;
         TYPE_SENSORS: need = 8'd18;
         TYPE_RC:      need = 8'd20;
         TYPE_MOTORS:  need = 8'd8;
         TYPE_PID:     need = 8'd18;
         default:      need = 8'd0;
      endcase
      return need;
   endfunction

endpackage

@@ hw/rtl/telemetry_frame_deframer.sv @@
// Top level of the telemetry frame deframer.
// Instantiates tfd_front, tfd_job_fifo and tfd_back; uses tfd_pkg.
//
// Usage:
//   The req_ channel takes one received byte per word (req_rx_byte). The parser
//   hunts for two header bytes equal to the header register, then takes a type,
//   a length, the payload and an 8-bit wrapping checksum of all earlier bytes.
//   A frame with a good checksum, a known type and enough payload yields its
//   fields on the rsp_ channel, one word per field, last_field set on the final one.
//   Input rate: one byte per cycle while req_stall is low. The payload store has
//   two banks; the parser raises req_stall only when the bank it would fill still
//   belongs to a frame whose fields have not all gone out.
//   After its checksum byte is taken, a frame goes through the job queue to the
//   emitter, which walks its fields one by one: a read state reads the payload memory
//   for the field, then a show state puts it on the port.
//   When the receiver holds rsp_stall, the current field stays on the port and
//   the parser keeps taking bytes into the other bank while that bank is free.
//   Reset (synchronous, active high) returns the parser to the header hunt, sets
//   the header register to 0xAA and empties the frame queue; payload memory
//   contents are left as they are. csr_wr_en writes the header register.
module telemetry_frame_deframer #(
   parameter int MAX_PAYLOAD = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_frame_type,
   output logic [3:0]         rsp_field_index,
   output logic signed [15:0] rsp_field_value,
   output logic [1:0]         rsp_scale_tag,
   output logic               rsp_last_field,
   input  logic               csr_wr_en,
   input  logic [7:0]         csr_wr_data
);

   localparam int ADDR_W = $clog2(2*MAX_PAYLOAD);

   // Payload write path from parser into the emitter's memory.
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;

   // Frame hand-off between the two halves.
   logic                 job_push;
   logic                 job_pop;
   logic                 job_empty;
   tfd_pkg::job_type     job_in;
   tfd_pkg::job_type     job_head;
   tfd_pkg::release_type bank_release;

   tfd_front #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_rx_byte  (req_rx_byte),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .job_push     (job_push),
      .job          (job_in),
      .bank_release (bank_release)
   );

   // At most one frame per payload bank is outstanding, so two slots never overflow.
   tfd_job_fifo u_job_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job_in),
      .pop      (job_pop),
      .empty    (job_empty),
      .head_job (job_head)
   );

   tfd_back #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .wr_en           (wr_en),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data),
      .job_empty       (job_empty),
      .job             (job_head),
      .job_pop         (job_pop),
      .bank_release    (bank_release),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_frame_type  (rsp_frame_type),
      .rsp_field_index (rsp_field_index),
      .rsp_field_value (rsp_field_value),
      .rsp_scale_tag   (rsp_scale_tag),
      .rsp_last_field  (rsp_last_field)
   );

endmodule

@@ hw/rtl/tfd_front.sv @@
// Byte parser of the telemetry frame deframer: header hunt, checksum, payload write.
// Depends on tfd_pkg; writes payload bytes into the emitter's double-buffered store.
module tfd_front #(
   parameter int MAX_PAYLOAD = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_rx_byte,
   input  logic                                csr_wr_en,
   input  logic [7:0]                          csr_wr_data,
   output logic                                wr_en,
   output logic [$clog2(2*MAX_PAYLOAD)-1:0]    wr_addr,
   output logic [7:0]                          wr_data,
   output logic                                job_push,
   output tfd_pkg::job_type                    job,
   input  tfd_pkg::release_type                bank_release
);

   localparam int OFF_W  = $clog2(MAX_PAYLOAD);
   localparam int ADDR_W = $clog2(2*MAX_PAYLOAD);
   localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

   typedef enum logic [5:0] {
      PH_HUNT  = 6'b000001,
      PH_HEAD2 = 6'b000010,
      PH_TYPE  = 6'b000100,
      PH_LEN   = 6'b001000,
      PH_DATA  = 6'b010000,
      PH_SUM   = 6'b100000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  header_ff, header_in;
   logic [7:0]  pos_ff, pos_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  len_ff, len_in;
   logic        bank_ff, bank_in;
   logic [1:0]  busy_ff, busy_in;

   logic        accept;
   logic [7:0]  b;
   logic [8:0]  pos_next;
   logic [OFF_W-1:0] wr_off;
   logic        frame_good;

   assign req_stall = busy_ff[bank_ff];
   assign accept    = req_valid && !req_stall;
   assign b         = req_rx_byte;
   assign pos_next  = {1'b0, pos_ff} + 9'd1;
   assign wr_off    = pos_ff[OFF_W-1:0];

   assign wr_en   = accept && (phase_ff == PH_DATA) && ({1'b0, pos_ff} < 9'(MAX_PAYLOAD));
   assign wr_addr = bank_ff ? (ADDR_W'(MAX_PAYLOAD) + ADDR_W'(wr_off)) : ADDR_W'(wr_off);
   assign wr_data = b;

   // A frame is handed on only with a matching checksum, a known type and enough payload.
   assign frame_good = (b == sum_ff) && (tfd_pkg::field_total(type_ff) != 4'd0) &&
                       (len_ff >= tfd_pkg::min_length(type_ff));
   assign job_push       = accept && (phase_ff == PH_SUM) && frame_good;
   assign job.frame_type = type_ff;
   assign job.bank       = bank_ff;

   always_comb begin
      phase_in  = phase_ff;
      header_in = csr_wr_en ? csr_wr_data : header_ff;
      pos_in    = pos_ff;
      sum_in    = sum_ff;
      type_in   = type_ff;
      len_in    = len_ff;
      bank_in   = bank_ff;
      busy_in   = busy_ff;
      if (bank_release.en) begin
         busy_in[bank_release.bank] = 1'b0;
      end
      if (accept) begin
         case (phase_ff)
            PH_HUNT: begin
               if (b == header_ff) begin
                  sum_in   = b;
                  phase_in = PH_HEAD2;
               end
            end
            PH_HEAD2: begin
               if (b == header_ff) begin
                  sum_in   = sum_ff + b;
                  phase_in = PH_TYPE;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_TYPE: begin
               type_in  = b;
               sum_in   = sum_ff + b;
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               sum_in = sum_ff + b;
               len_in = b;
               pos_in = 8'd0;
               if (b > MAX_LEN) begin
                  phase_in = PH_HUNT;
               end else if (b == 8'd0) begin
                  phase_in = PH_SUM;
               end else begin
                  phase_in = PH_DATA;
               end
            end
            PH_DATA: begin
               sum_in = sum_ff + b;
               pos_in = pos_next[7:0];
               if (pos_next >= {1'b0, len_ff}) begin
                  phase_in = PH_SUM;
               end
            end
            PH_SUM: begin
               if (frame_good) begin
                  busy_in[bank_ff] = 1'b1;
                  bank_in          = !bank_ff;
               end
               phase_in = PH_HUNT;
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         header_ff <= 8'hAA;
         pos_ff    <= 8'd0;
         sum_ff    <= 8'd0;
         type_ff   <= 8'd0;
         len_ff    <= 8'd0;
         bank_ff   <= 1'b0;
         busy_ff   <= 2'b00;
      end else begin
         phase_ff  <= phase_in;
         header_ff <= header_in;
         pos_ff    <= pos_in;
         sum_ff    <= sum_in;
         type_ff   <= type_in;
         len_ff    <= len_in;
         bank_ff   <= bank_in;
         busy_ff   <= busy_in;
      end
   end

endmodule

@@ hw/rtl/tfd_job_fifo.sv @@
// Two-entry queue of validated frames between the parser and the field emitter.
// Depends on tfd_pkg for the job record.
module tfd_job_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tfd_pkg::job_type push_job,
   input  logic             pop,
   output logic             empty,
   output tfd_pkg::job_type head_job
);

   tfd_pkg::job_type slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign empty    = (count_ff == 2'd0);
   assign head_job = slot_ff[rd_ptr_ff];
   assign do_push  = push && (count_ff != 2'd2);
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ hw/rtl/tfd_back.sv @@
// Field emitter of the telemetry frame deframer: holds the double-buffered payload
// store and walks a frame's layout one result word at a time. Depends on tfd_pkg.
module tfd_back #(
   parameter int MAX_PAYLOAD = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic [$clog2(2*MAX_PAYLOAD)-1:0] wr_addr,
   input  logic [7:0]                       wr_data,
   input  logic                             job_empty,
   input  tfd_pkg::job_type                 job,
   output logic                             job_pop,
   output tfd_pkg::release_type             bank_release,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [7:0]                       rsp_frame_type,
   output logic [3:0]                       rsp_field_index,
   output logic signed [15:0]               rsp_field_value,
   output logic [1:0]                       rsp_scale_tag,
   output logic                             rsp_last_field
);

   localparam int ADDR_W = $clog2(2*MAX_PAYLOAD);

   typedef enum logic [2:0] {
      BE_IDLE = 3'b001,
      BE_READ = 3'b010,
      BE_SHOW = 3'b100
   } be_state_type;

   logic [7:0] mem [2*MAX_PAYLOAD];

   be_state_type state_ff, state_in;
   logic [7:0]   type_ff, type_in;
   logic         bank_ff, bank_in;
   logic [3:0]   total_ff, total_in;
   logic [3:0]   k_ff, k_in;
   logic [1:0]   m3_ff, m3_in;
   logic [7:0]   rd_a_ff, rd_b_ff;

   logic             is_armed;
   logic             is_last;
   logic [4:0]       off_a, off_b;
   logic [ADDR_W-1:0] base, addr_a, addr_b;
   logic             rd_en;
   logic             shown;

   assign is_armed = (type_ff == tfd_pkg::TYPE_STATUS) && (k_ff == tfd_pkg::ARMED_INDEX);
   assign is_last  = (k_ff + 4'd1 == total_ff);
   assign off_a    = is_armed ? tfd_pkg::ARMED_OFFSET : {k_ff, 1'b0};
   assign off_b    = {k_ff, 1'b1};
   assign base     = bank_ff ? ADDR_W'(MAX_PAYLOAD) : ADDR_W'(0);
   assign addr_a   = base + ADDR_W'(off_a);
   assign addr_b   = base + ADDR_W'(off_b);
   assign rd_en    = (state_ff == BE_READ);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem[addr_a];
         rd_b_ff <= mem[addr_b];
      end
   end

   assign rsp_valid       = (state_ff == BE_SHOW);
   assign shown           = rsp_valid && !rsp_stall;
   assign rsp_frame_type  = type_ff;
   assign rsp_field_index = k_ff;
   assign rsp_last_field  = is_last;
   assign rsp_field_value = is_armed ?
                            ((rd_a_ff == tfd_pkg::DISARMED_CODE) ? 16'sd0 : 16'sd1) :
                            $signed({rd_a_ff, rd_b_ff});

   // PID gains: the middle of each triple is the integral term.
   always_comb begin
      if (type_ff == tfd_pkg::TYPE_PID) begin
         rsp_scale_tag = (m3_ff == 2'd1) ? tfd_pkg::SCALE_THOUSANDTHS
                                         : tfd_pkg::SCALE_HUNDREDTHS;
      end else begin
         rsp_scale_tag = tfd_pkg::SCALE_RAW;
      end
   end

   assign job_pop           = (state_ff == BE_IDLE) && !job_empty;
   assign bank_release.en   = shown && is_last;
   assign bank_release.bank = bank_ff;

   always_comb begin
      state_in = state_ff;
      type_in  = type_ff;
      bank_in  = bank_ff;
      total_in = total_ff;
      k_in     = k_ff;
      m3_in    = m3_ff;
      case (state_ff)
         BE_IDLE: begin
            if (!job_empty) begin
               type_in  = job.frame_type;
               bank_in  = job.bank;
               total_in = tfd_pkg::field_total(job.frame_type);
               k_in     = 4'd0;
               m3_in    = 2'd0;
               state_in = BE_READ;
            end
         end
         BE_READ: begin
            state_in = BE_SHOW;
         end
         BE_SHOW: begin
            if (!rsp_stall) begin
               if (is_last) begin
                  state_in = BE_IDLE;
               end else begin
                  k_in     = k_ff + 4'd1;
                  m3_in    = (m3_ff == 2'd2) ? 2'd0 : m3_ff + 2'd1;
                  state_in = BE_READ;
               end
            end
         end
         default: begin
            state_in = BE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BE_IDLE;
         type_ff  <= 8'd0;
         bank_ff  <= 1'b0;
         total_ff <= 4'd0;
         k_ff     <= 4'd0;
         m3_ff    <= 2'd0;
      end else begin
         state_ff <= state_in;
         type_ff  <= type_in;
         bank_ff  <= bank_in;
         total_ff <= total_in;
         k_ff     <= k_in;
         m3_ff    <= m3_in;
      end
   end

endmodule
